// File: rtl/cmts_pkg.sv
// ----------------------------------------------------------------------------
// cmts_pkg
// Shared types and constants for the corner marker triplet selector.
// ----------------------------------------------------------------------------
package cmts_pkg;

  localparam int COORD_BITS = 12;
  localparam int REG_BITS   = 12;
  localparam int VEC_BITS   = COORD_BITS + 1;
  localparam int MAG_BITS   = 2 * VEC_BITS;
  localparam int PROD_BITS  = 2 * MAG_BITS;
  localparam int POINT_BITS = 2 * COORD_BITS;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BL = 2'd2;
  localparam logic [1:0] CORNER_BR = 2'd3;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CORNER_RADIUS = 2'd2;

  typedef struct packed {
    logic [REG_BITS-1:0] width;
    logic [REG_BITS-1:0] height;
    logic [REG_BITS-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic                  last;
    logic                  hit;
    logic [1:0]            corner;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [COORD_BITS-1:0] tl_x;
    logic [COORD_BITS-1:0] tl_y;
    logic [COORD_BITS-1:0] tr_x;
    logic [COORD_BITS-1:0] tr_y;
    logic [COORD_BITS-1:0] third_x;
    logic [COORD_BITS-1:0] third_y;
    logic                  third_is_br;
    logic                  overflow;
  } result_t;

endpackage

// File: rtl/cmts_ram.sv
// ----------------------------------------------------------------------------
// cmts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmts_ram #(
  parameter int Width = 24,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/cmts_front.sv
// ----------------------------------------------------------------------------
// cmts_front
// Registers incoming points and tags each with the first corner in range.
// ----------------------------------------------------------------------------
module cmts_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmts_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cmts_pkg::COORD_BITS-1:0] point_x_i,
  input  logic [cmts_pkg::COORD_BITS-1:0] point_y_i,
  input  logic                            last_point_i,
  input  logic                            full_i,
  output logic                            push_o,
  output cmts_pkg::item_t                 item_o
);

  localparam int SqBits = 2 * cmts_pkg::COORD_BITS;

  logic                            vld_q;
  logic [cmts_pkg::COORD_BITS-1:0] x_q, y_q;
  logic                            last_q;

  logic [cmts_pkg::COORD_BITS-1:0] ax_r, ay_b;
  logic [SqBits-1:0]               sq_xl, sq_xr, sq_yt, sq_yb, r_sq;
  logic [SqBits:0]                 d_tl, d_tr, d_bl, d_br, lim;

  assign push_o     = vld_q && !full_i;
  assign in_ready_o = !vld_q || !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q    <= point_x_i;
      y_q    <= point_y_i;
      last_q <= last_point_i;
    end
  end

  // Distances to the far edges as magnitudes, so every square is unsigned.
  always_comb begin
    ax_r  = (x_q >= cfg_i.width)  ? x_q - cfg_i.width  : cfg_i.width  - x_q;
    ay_b  = (y_q >= cfg_i.height) ? y_q - cfg_i.height : cfg_i.height - y_q;
    sq_xl = x_q * x_q;
    sq_xr = ax_r * ax_r;
    sq_yt = y_q * y_q;
    sq_yb = ay_b * ay_b;
    r_sq  = cfg_i.radius * cfg_i.radius;
    d_tl  = {1'b0, sq_xl} + {1'b0, sq_yt};
    d_tr  = {1'b0, sq_xr} + {1'b0, sq_yt};
    d_bl  = {1'b0, sq_xl} + {1'b0, sq_yb};
    d_br  = {1'b0, sq_xr} + {1'b0, sq_yb};
    lim   = {1'b0, r_sq};

    item_o.last   = last_q;
    item_o.x      = x_q;
    item_o.y      = y_q;
    item_o.hit    = 1'b1;
    if (d_tl < lim) begin
      item_o.corner = cmts_pkg::CORNER_TL;
    end else if (d_tr < lim) begin
      item_o.corner = cmts_pkg::CORNER_TR;
    end else if (d_bl < lim) begin
      item_o.corner = cmts_pkg::CORNER_BL;
    end else if (d_br < lim) begin
      item_o.corner = cmts_pkg::CORNER_BR;
    end else begin
      item_o.corner = cmts_pkg::CORNER_TL;
      item_o.hit    = 1'b0;
    end
  end

endmodule

// File: rtl/cmts_queue.sv
// ----------------------------------------------------------------------------
// cmts_queue
// Two-entry queue between the classifier and the search engine.
// ----------------------------------------------------------------------------
module cmts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cmts_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cmts_pkg::item_t item_o
);

  cmts_pkg::item_t mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/cmts_back.sv
// ----------------------------------------------------------------------------
// cmts_back
// Stores tagged points per corner and runs the triple search on the last item.
// ----------------------------------------------------------------------------
module cmts_back #(
  parameter int MaxPerCorner = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmts_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmts_pkg::result_t result_o
);

  localparam int CW = $clog2(MaxPerCorner + 1);
  localparam int IW = (MaxPerCorner > 1) ? $clog2(MaxPerCorner) : 1;
  localparam int CB = cmts_pkg::COORD_BITS;
  localparam int VB = cmts_pkg::VEC_BITS;
  localparam int MB = cmts_pkg::MAG_BITS;
  localparam int PB = cmts_pkg::PROD_BITS;
  localparam int PT = cmts_pkg::POINT_BITS;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state_q;
  logic [CW-1:0]     cnt_q [4];
  logic              ovf_q;
  logic [IW-1:0]     i_q, j_q, t_q;
  logic              pass_q, have_q;
  logic [MB-1:0]     best_d_q, best_c_q, d_q, c_q;
  logic [PB-1:0]     lhs_q, rhs_q;
  logic signed [2*VB-1:0] pxx_q, pyy_q, pxy_q, pyx_q;
  logic [PT-1:0]     cand_tl_q, cand_tr_q, cand_q_q;
  cmts_pkg::result_t best_q, out_q;
  cmts_pkg::result_t done_res;
  logic              out_valid_q;

  logic [PT-1:0]     rd [4];
  logic [IW-1:0]     raddr [4];
  logic              we;
  logic [CW-1:0]     cur_cnt;
  logic              full_k;

  // Datapath of the read stage
  logic [PT-1:0]          v_pt, p_pt, q_pt;
  logic signed [VB-1:0]   ux, uy, wx, wy;
  logic signed [2*VB:0]   dot, crs;
  logic [MB-1:0]          dmag, cmag;
  logic                   t_last, j_last, i_last, first_pass;

  assign full_k  = cnt_q[q_item_i.corner] == CW'(MaxPerCorner);
  assign q_pop_o = (state_q == S_LOAD) && q_valid_i;
  assign we      = q_pop_o && q_item_i.hit && !full_k;

  assign raddr[0] = i_q;
  assign raddr[1] = j_q;
  assign raddr[2] = t_q;
  assign raddr[3] = t_q;

  for (genvar g = 0; g < 4; g++) begin : g_list
    cmts_ram #(
      .Width (PT),
      .Depth (MaxPerCorner)
    ) u_list (
      .clk_i   (clk_i),
      .we_i    (we && (q_item_i.corner == 2'(g))),
      .waddr_i (cnt_q[g][IW-1:0]),
      .wdata_i ({q_item_i.x, q_item_i.y}),
      .raddr_i (raddr[g]),
      .rdata_o (rd[g])
    );
  end

  always_comb begin
    q_pt = pass_q ? rd[cmts_pkg::CORNER_BL] : rd[cmts_pkg::CORNER_BR];
    // Vertex is TR for the bottom-right pass, TL for the bottom-left pass
    v_pt = pass_q ? rd[cmts_pkg::CORNER_TL] : rd[cmts_pkg::CORNER_TR];
    p_pt = pass_q ? rd[cmts_pkg::CORNER_TR] : rd[cmts_pkg::CORNER_TL];
    ux = $signed({1'b0, p_pt[PT-1:CB]}) - $signed({1'b0, v_pt[PT-1:CB]});
    uy = $signed({1'b0, p_pt[CB-1:0]})  - $signed({1'b0, v_pt[CB-1:0]});
    wx = $signed({1'b0, q_pt[PT-1:CB]}) - $signed({1'b0, v_pt[PT-1:CB]});
    wy = $signed({1'b0, q_pt[CB-1:0]})  - $signed({1'b0, v_pt[CB-1:0]});

    dot  = {pxx_q[2*VB-1], pxx_q} + {pyy_q[2*VB-1], pyy_q};
    crs  = {pxy_q[2*VB-1], pxy_q} - {pyx_q[2*VB-1], pyx_q};
    dmag = dot[2*VB] ? MB'(-dot) : MB'(dot);
    cmag = crs[2*VB] ? MB'(-crs) : MB'(crs);

    cur_cnt    = pass_q ? cnt_q[cmts_pkg::CORNER_BL] : cnt_q[cmts_pkg::CORNER_BR];
    first_pass = cnt_q[cmts_pkg::CORNER_BR] == '0;
    t_last = ({1'b0, CW'(t_q)} + (CW+1)'(1)) >= {1'b0, cur_cnt};
    j_last = ({1'b0, CW'(j_q)} + (CW+1)'(1)) >= {1'b0, cnt_q[cmts_pkg::CORNER_TR]};
    i_last = ({1'b0, CW'(i_q)} + (CW+1)'(1)) >= {1'b0, cnt_q[cmts_pkg::CORNER_TL]};
  end

  always_comb begin
    done_res          = best_q;
    done_res.overflow = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      for (int k = 0; k < 4; k++) begin
        cnt_q[k] <= '0;
      end
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      t_q         <= '0;
      pass_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (q_pop_o) begin
            if (q_item_i.hit) begin
              if (full_k) begin
                ovf_q <= 1'b1;
              end else begin
                cnt_q[q_item_i.corner] <= cnt_q[q_item_i.corner] + CW'(1);
              end
            end
            if (q_item_i.last) begin
              state_q <= S_START;
            end
          end
        end
        S_START: begin
          have_q <= 1'b0;
          i_q    <= '0;
          j_q    <= '0;
          t_q    <= '0;
          pass_q <= first_pass;
          if (cnt_q[cmts_pkg::CORNER_TL] == '0 || cnt_q[cmts_pkg::CORNER_TR] == '0 ||
              (cnt_q[cmts_pkg::CORNER_BL] == '0 && first_pass)) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR: state_q <= S_RD;
        S_RD:   state_q <= S_SUM;
        S_SUM:  state_q <= S_MUL;
        S_MUL:  state_q <= S_CMP;
        S_CMP: begin
          if (!have_q || lhs_q < rhs_q) begin
            have_q <= 1'b1;
          end
          state_q <= S_ADDR;
          if (!t_last) begin
            t_q <= t_q + IW'(1);
          end else if (!pass_q && cnt_q[cmts_pkg::CORNER_BL] != '0) begin
            pass_q <= 1'b1;
            t_q    <= '0;
          end else begin
            pass_q <= first_pass;
            t_q    <= '0;
            if (!j_last) begin
              j_q <= j_q + IW'(1);
            end else begin
              j_q <= '0;
              if (!i_last) begin
                i_q <= i_q + IW'(1);
              end else begin
                state_q <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            for (int k = 0; k < 4; k++) begin
              cnt_q[k] <= '0;
            end
            ovf_q   <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_START: best_q <= '0;
      S_RD: begin
        pxx_q     <= ux * wx;
        pyy_q     <= uy * wy;
        pxy_q     <= ux * wy;
        pyx_q     <= uy * wx;
        cand_tl_q <= rd[cmts_pkg::CORNER_TL];
        cand_tr_q <= rd[cmts_pkg::CORNER_TR];
        cand_q_q  <= q_pt;
      end
      S_SUM: begin
        // A degenerate arm counts as the worst deviation
        d_q <= (dmag == '0 && cmag == '0) ? MB'(1) : dmag;
        c_q <= cmag;
      end
      S_MUL: begin
        lhs_q <= d_q * best_c_q;
        rhs_q <= best_d_q * c_q;
      end
      S_CMP: begin
        if (!have_q || lhs_q < rhs_q) begin
          best_d_q           <= d_q;
          best_c_q           <= c_q;
          best_q.found       <= 1'b1;
          best_q.tl_x        <= cand_tl_q[PT-1:CB];
          best_q.tl_y        <= cand_tl_q[CB-1:0];
          best_q.tr_x        <= cand_tr_q[PT-1:CB];
          best_q.tr_y        <= cand_tr_q[CB-1:0];
          best_q.third_x     <= cand_q_q[PT-1:CB];
          best_q.third_y     <= cand_q_q[CB-1:0];
          best_q.third_is_br <= !pass_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= done_res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

// File: rtl/corner_marker_triplet_select.sv
// ----------------------------------------------------------------------------
// corner_marker_triplet_select
// Sorts marker centres into corner lists and picks the squarest corner triple.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one point per item; points
//   load at one per cycle while no search runs. Each point joins the list
//   of the first corner (TL, TR, BL, BR) within corner_radius; others are
//   dropped. An item with last_point_i set starts the search. One result
//   item then appears on the output channel (out_valid_o/out_ready_i) once
//   every candidate triple, one at a time, has passed through the list RAM
//   read, product, sum, multiply and compare steps of the single search
//   engine. Loading stalls during the search.
//   A finished result waits in an output register; if the receiver stalls,
//   the next set loads until another search ends.
//   Reset empties all lists, clears overflow and restores the registers
//   (width 2480, height 3508, radius 200). Write the APB registers only
//   while the block is idle.
// ----------------------------------------------------------------------------
module corner_marker_triplet_select #(
  parameter int MaxPerCorner = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] point_x_i,
  input  logic [11:0] point_y_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [11:0] top_left_x_o,
  output logic [11:0] top_left_y_o,
  output logic [11:0] top_right_x_o,
  output logic [11:0] top_right_y_o,
  output logic [11:0] third_x_o,
  output logic [11:0] third_y_o,
  output logic        third_is_bottom_right_o,
  output logic        list_overflow_o
);

  cmts_pkg::cfg_t    cfg_q;
  cmts_pkg::item_t   f_item, q_item;
  cmts_pkg::result_t result;
  logic              push, full, q_valid, pop;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 12'd2480;
      cfg_q.height <= 12'd3508;
      cfg_q.radius <= 12'd200;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        cmts_pkg::REG_IMAGE_WIDTH:   cfg_q.width  <= pwdata[cmts_pkg::REG_BITS-1:0];
        cmts_pkg::REG_IMAGE_HEIGHT:  cfg_q.height <= pwdata[cmts_pkg::REG_BITS-1:0];
        cmts_pkg::REG_CORNER_RADIUS: cfg_q.radius <= pwdata[cmts_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cmts_pkg::REG_IMAGE_WIDTH:   prdata = {20'd0, cfg_q.width};
      cmts_pkg::REG_IMAGE_HEIGHT:  prdata = {20'd0, cfg_q.height};
      cmts_pkg::REG_CORNER_RADIUS: prdata = {20'd0, cfg_q.radius};
      default:                     prdata = 32'd0;
    endcase
  end

  cmts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (f_item)
  );

  cmts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cmts_back #(
    .MaxPerCorner (MaxPerCorner)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign found_o                 = result.found;
  assign top_left_x_o            = result.tl_x;
  assign top_left_y_o            = result.tl_y;
  assign top_right_x_o           = result.tr_x;
  assign top_right_y_o           = result.tr_y;
  assign third_x_o               = result.third_x;
  assign third_y_o               = result.third_y;
  assign third_is_bottom_right_o = result.third_is_br;
  assign list_overflow_o         = result.overflow;

endmodule
